// File: hdl/bptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bptc_pkg;
    localparam int DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_B1_B2 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MC_MD = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OSS = 3'd5;
    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] X3_OFFSET = 32'd32768;
    localparam logic [15:0] B7_SCALE = 16'd50000;
    localparam logic [31:0] P_MSB = 32'h8000_0000;
    localparam logic [11:0] P_C1 = 12'd3038;
    localparam logic [12:0] P_C2 = 13'd7357;
    localparam logic [31:0] P_C3 = 32'd3791;
    localparam logic [31:0] TEMP_MIN = 32'hFFFF_F800;
    localparam logic [31:0] TEMP_MAX = 32'd2047;
    localparam logic [31:0] PRESS_MAX = 32'd262143;
endpackage
`default_nettype wire

// File: hdl/bptc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bptc_div #(
    parameter int DW = bptc_pkg::DATA_W,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DW-1:0]     dividend,
    input  wire logic [DW-1:0]     divisor,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [DW-1:0]          quotient,
    output logic [SIDE_W-1:0]      side_out
);
    import bptc_pkg::*;

    logic [DW-1:0]     rem_reg [DW];
    logic [DW-1:0]     quo_reg [DW];
    logic [DW-1:0]     dvs_reg [DW];
    logic [SIDE_W-1:0] side_reg [DW];
    logic [DW-1:0]     vld_reg;

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] quo_in;
        logic [DW-1:0] dvs_in;
        logic [SIDE_W-1:0] side_prev;
        logic          vld_in;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = dividend;
            assign dvs_in = divisor;
            assign side_prev = side_in;
            assign vld_in = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end
        assign trial = {rem_in, quo_in[DW-1]};
        assign ge = trial >= {1'b0, dvs_in};
        assign diff = trial - {1'b0, dvs_in};
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end
        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                quo_reg[k] <= {quo_in[DW-2:0], ge};
                dvs_reg[k] <= dvs_in;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[DW-1];
    assign quotient = quo_reg[DW-1];
    assign side_out = side_reg[DW-1];
endmodule
`default_nettype wire

// File: hdl/baro_pressure_temp_compensation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Fully pipelined barometer compensation: one item may enter every clock cycle while the
// result side is not stalled. The pipeline holds two 32-stage bit-per-stage dividers
// (temperature divisor and pressure divisor) plus the multiplier stages around them.
// A stall on the result side freezes the whole pipeline. Configuration
// must be written through the cfg port only while no item is in flight, which the block
// does not enforce; a zero divisor gives div_error with zero results.
module baro_pressure_temp_compensation_top #(
    parameter int DW = bptc_pkg::DATA_W
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // raw_temp[15:0], raw_press[39:16]
    input  wire logic [39:0]                     s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // temp_tenths[11:0], press_pa[29:12], div_error[30], zero[31]
    output logic [31:0]                          m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bptc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [31:0]                     cfg_data
);
    import bptc_pkg::*;

    logic [31:0] c01_reg, c23_reg, c45_reg, cb_reg, cm_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            c01_reg <= '0;
            c23_reg <= '0;
            c45_reg <= '0;
            cb_reg <= '0;
            cm_reg <= '0;
            oss_reg <= 2'd3;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_AC1_AC2: c01_reg <= cfg_data;
                REG_AC3_AC4: c23_reg <= cfg_data;
                REG_AC5_AC6: c45_reg <= cfg_data;
                REG_B1_B2:   cb_reg <= cfg_data;
                REG_MC_MD:   cm_reg <= cfg_data;
                REG_OSS:     oss_reg <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{c01_reg[31]}}, c01_reg[31:16]};
    assign ac2 = {{16{c01_reg[15]}}, c01_reg[15:0]};
    assign ac3 = {{16{c23_reg[31]}}, c23_reg[31:16]};
    assign ac4 = {16'd0, c23_reg[15:0]};
    assign ac5 = {16'd0, c45_reg[31:16]};
    assign ac6 = {16'd0, c45_reg[15:0]};
    assign b1 = {{16{cb_reg[31]}}, cb_reg[31:16]};
    assign b2 = {{16{cb_reg[15]}}, cb_reg[15:0]};
    assign mc = {{16{cm_reg[31]}}, cm_reg[31:16]};
    assign md = {{16{cm_reg[15]}}, cm_reg[15:0]};

    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage A: first multiply.
    logic        va_reg;
    logic [31:0] a_prod_reg;
    logic [23:0] a_up_reg;
    logic [31:0] ut_diff;
    logic [23:0] up_sh;
    assign ut_diff = {16'd0, s_tdata[15:0]} - ac6;
    assign up_sh = s_tdata[39:16] >> (4'd8 - {2'd0, oss_reg});

    // Stage B: divider operands for the temperature divisor.
    logic        vb_reg;
    logic [31:0] b_x1_reg, b_num_reg, b_den_reg;
    logic [23:0] b_up_reg;
    logic        b_err_reg, b_neg_reg;
    logic [31:0] x1_t, den_t, num_t;
    assign x1_t = $signed(a_prod_reg) >>> 15;
    assign den_t = x1_t + md;
    assign num_t = mc << 11;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
        end
    end
    always_ff @(posedge clk) begin
        if (adv) begin
            a_prod_reg <= 32'(ut_diff * ac5);
            a_up_reg <= up_sh;
            b_x1_reg <= x1_t;
            b_up_reg <= a_up_reg;
            b_err_reg <= den_t == '0;
            b_neg_reg <= num_t[31] ^ den_t[31];
            b_num_reg <= num_t[31] ? 32'(-num_t) : num_t;
            b_den_reg <= den_t[31] ? 32'(-den_t) : den_t;
        end
    end

    localparam int S1_W = 32 + 24 + 2;
    logic            d1_valid;
    logic [DW-1:0]   d1_quo;
    logic [S1_W-1:0] d1_side;
    bptc_div #(.DW(DW), .SIDE_W(S1_W)) u_div_t (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(vb_reg),
        .dividend(b_num_reg), .divisor(b_den_reg),
        .side_in({b_x1_reg, b_up_reg, b_err_reg, b_neg_reg}),
        .out_valid(d1_valid), .quotient(d1_quo), .side_out(d1_side)
    );

    logic [31:0] x2_t, b5_t, t32;
    assign x2_t = d1_side[0] ? 32'(-d1_quo) : d1_quo;
    assign b5_t = d1_side[57:26] + x2_t;
    assign t32 = $signed(b5_t + 32'd8) >>> 4;

    // Stage P1 .. P7 registers.
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [11:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    logic        e1_reg, e2_reg, e3_reg, e4_reg, e5_reg, e6_reg;
    logic [23:0] u1_reg, u2_reg, u3_reg, u4_reg, u5_reg;
    logic [31:0] b6_reg, m66_reg, m26_reg, m36_reg;
    logic [31:0] sq_reg, x2a3_reg, x1b3_reg, x2a4_reg, x1b4_reg, mb2_reg, mb1_reg;
    logic [31:0] b3_reg, x3b_reg, ub_reg, m4_reg, b4_reg, b7_reg;
    logic        e7_reg;
    logic [11:0] t_sat;
    logic [31:0] x3_t, tmp_t, tmp_s, x3b_t, b4_t, num2_t;
    logic [31:0] mb2_sh, mb1_sh;

    always_comb begin
        if ($signed(t32) < $signed(TEMP_MIN)) begin
            t_sat = TEMP_MIN[11:0];
        end else if ($signed(t32) > $signed(TEMP_MAX)) begin
            t_sat = TEMP_MAX[11:0];
        end else begin
            t_sat = t32[11:0];
        end
    end

    assign mb2_sh = $signed(mb2_reg) >>> 11;
    assign mb1_sh = $signed(mb1_reg) >>> 16;
    assign x3_t = mb2_sh + x2a4_reg;
    assign tmp_t = (((ac1 << 2) + x3_t) << oss_reg) + 32'd2;
    assign tmp_s = tmp_t + (tmp_t[31] ? 32'd3 : 32'd0);
    assign x3b_t = $signed(x1b4_reg + mb1_sh + 32'd2) >>> 2;
    assign b4_t = m4_reg >> 15;
    assign num2_t = (b7_reg < P_MSB) ? (b7_reg << 1) : b7_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= d1_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end
    always_ff @(posedge clk) begin
        if (adv) begin
            b6_reg <= b5_t - B6_OFFSET;
            t1_reg <= t_sat;
            e1_reg <= d1_side[1];
            u1_reg <= d1_side[25:2];

            m66_reg <= 32'(b6_reg * b6_reg);
            m26_reg <= 32'(ac2 * b6_reg);
            m36_reg <= 32'(ac3 * b6_reg);
            t2_reg <= t1_reg;
            e2_reg <= e1_reg;
            u2_reg <= u1_reg;

            sq_reg <= $signed(m66_reg) >>> 12;
            x2a3_reg <= $signed(m26_reg) >>> 11;
            x1b3_reg <= $signed(m36_reg) >>> 13;
            t3_reg <= t2_reg;
            e3_reg <= e2_reg;
            u3_reg <= u2_reg;

            mb2_reg <= 32'(b2 * sq_reg);
            mb1_reg <= 32'(b1 * sq_reg);
            x2a4_reg <= x2a3_reg;
            x1b4_reg <= x1b3_reg;
            t4_reg <= t3_reg;
            e4_reg <= e3_reg;
            u4_reg <= u3_reg;

            b3_reg <= $signed(tmp_s) >>> 2;
            x3b_reg <= x3b_t;
            t5_reg <= t4_reg;
            e5_reg <= e4_reg;
            u5_reg <= u4_reg;

            m4_reg <= 32'(ac4 * (x3b_reg + X3_OFFSET));
            ub_reg <= {8'd0, u5_reg} - b3_reg;
            t6_reg <= t5_reg;
            e6_reg <= e5_reg;

            b4_reg <= b4_t;
            b7_reg <= 32'(ub_reg * {16'd0, B7_SCALE >> oss_reg});
            e7_reg <= e6_reg || (b4_t == '0);
            t7_reg <= t6_reg;
        end
    end

    localparam int S2_W = 14;
    logic            d2_valid;
    logic [DW-1:0]   d2_quo;
    logic [S2_W-1:0] d2_side;
    bptc_div #(.DW(DW), .SIDE_W(S2_W)) u_div_p (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v7_reg),
        .dividend(num2_t), .divisor(b4_reg),
        .side_in({t7_reg, e7_reg, b7_reg >= P_MSB}),
        .out_valid(d2_valid), .quotient(d2_quo), .side_out(d2_side)
    );

    logic        q1_v_reg, q2_v_reg, q3_v_reg, out_v_reg;
    logic [31:0] p1_reg, p2_reg, p3_reg, sqp_reg, m7_reg, m3_reg, x2p_reg;
    logic [11:0] qt1_reg, qt2_reg, qt3_reg, out_t_reg;
    logic        qe1_reg, qe2_reg, qe3_reg, out_e_reg;
    logic [17:0] out_p_reg;
    logic [31:0] x1p_t, pf_t;
    logic [31:0] m3_sh, pc_sum, pc_sh;
    logic [17:0] p_sat;
    assign x1p_t = $signed(p1_reg) >>> 8;
    assign m3_sh = $signed(m3_reg) >>> 16;
    assign pc_sum = m3_sh + x2p_reg + P_C3;
    assign pc_sh = $signed(pc_sum) >>> 4;
    assign pf_t = p3_reg + pc_sh;
    always_comb begin
        if (pf_t[31]) begin
            p_sat = '0;
        end else if (pf_t > PRESS_MAX) begin
            p_sat = PRESS_MAX[17:0];
        end else begin
            p_sat = pf_t[17:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            q1_v_reg <= 1'b0;
            q2_v_reg <= 1'b0;
            q3_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            q1_v_reg <= d2_valid;
            q2_v_reg <= q1_v_reg;
            q3_v_reg <= q2_v_reg;
            out_v_reg <= q3_v_reg;
        end
    end
    always_ff @(posedge clk) begin
        if (adv) begin
            p1_reg <= d2_side[0] ? (d2_quo << 1) : d2_quo;
            qt1_reg <= d2_side[13:2];
            qe1_reg <= d2_side[1];

            sqp_reg <= 32'(x1p_t * x1p_t);
            m7_reg <= 32'(p1_reg * {19'd0, P_C2});
            p2_reg <= p1_reg;
            qt2_reg <= qt1_reg;
            qe2_reg <= qe1_reg;

            m3_reg <= 32'(sqp_reg * {20'd0, P_C1});
            x2p_reg <= $signed(32'(-m7_reg)) >>> 16;
            p3_reg <= p2_reg;
            qt3_reg <= qt2_reg;
            qe3_reg <= qe2_reg;

            out_t_reg <= qe3_reg ? '0 : qt3_reg;
            out_p_reg <= qe3_reg ? '0 : p_sat;
            out_e_reg <= qe3_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = {1'b0, out_e_reg, out_p_reg, out_t_reg};

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[30] |-> m_tdata[29:0] == '0)
        else $error("error result carries nonzero fields");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
endmodule
`default_nettype wire

// File: tb/baro_comp_checker.sv
`timescale 1ns / 1ps
module baro_comp_checker
    import bptc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    logic [31:0] coef_ac12, coef_ac34, coef_ac56, coef_b12, coef_mcmd;
    logic [1:0]  oss_setting;
    logic [31:0] expected_results[$];

    assign pending = expected_results.size();

    function automatic logic [31:0] asr(logic [31:0] v, int s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sdiv32(logic [31:0] a, logic [31:0] b);
        longint q;
        q = longint'($signed(a)) / longint'($signed(b));
        return q[31:0];
    endfunction

    function automatic logic [31:0] sx(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] compensate(logic [15:0] raw_t, logic [23:0] raw_p);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
        int oss;
        longint t, pr;
        logic [11:0] t_out;
        logic [17:0] p_out;
        ac1 = sx(coef_ac12[31:16]);
        ac2 = sx(coef_ac12[15:0]);
        ac3 = sx(coef_ac34[31:16]);
        ac4 = {16'd0, coef_ac34[15:0]};
        ac5 = {16'd0, coef_ac56[31:16]};
        ac6 = {16'd0, coef_ac56[15:0]};
        b1 = sx(coef_b12[31:16]);
        b2 = sx(coef_b12[15:0]);
        mc = sx(coef_mcmd[31:16]);
        md = sx(coef_mcmd[15:0]);
        oss = oss_setting;
        ut = {16'd0, raw_t};
        up = {8'd0, raw_p} >> (8 - oss);
        x1 = asr((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0)
            return {1'b0, 1'b1, 30'd0};
        x2 = sdiv32(mc << 11, den);
        b5 = x1 + x2;
        b6 = b5 - B6_OFFSET;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sdiv32(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + X3_OFFSET)) >> 15;
        if (b4 == 0)
            return {1'b0, 1'b1, 30'd0};
        b7 = (up - b3) * (32'(B7_SCALE) >> oss);
        if (b7 < P_MSB)
            p = (b7 * 32'd2) / b4;
        else
            p = (b7 / b4) * 32'd2;
        x1 = asr(p, 8);
        x1 = x1 * x1;
        x1 = asr(x1 * 32'(P_C1), 16);
        x2 = asr((32'd0 - 32'(P_C2)) * p, 16);
        p = p + asr(x1 + x2 + P_C3, 4);
        t = longint'($signed(asr(b5 + 32'd8, 4)));
        if (t < -2048) t = -2048;
        if (t > 2047) t = 2047;
        pr = longint'($signed(p));
        if (pr < 0) pr = 0;
        if (pr > 262143) pr = 262143;
        t_out = t[11:0];
        p_out = pr[17:0];
        return {1'b0, 1'b0, p_out, t_out};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_ac12 <= '0;
            coef_ac34 <= '0;
            coef_ac56 <= '0;
            coef_b12 <= '0;
            coef_mcmd <= '0;
            oss_setting <= 2'd3;
            fail_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    REG_AC1_AC2: coef_ac12 <= cfg_data;
                    REG_AC3_AC4: coef_ac34 <= cfg_data;
                    REG_AC5_AC6: coef_ac56 <= cfg_data;
                    REG_B1_B2: coef_b12 <= cfg_data;
                    REG_MC_MD: coef_mcmd <= cfg_data;
                    REG_OSS: oss_setting <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(compensate(s_tdata[15:0], s_tdata[39:16]));
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result item %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (m_tdata[11:0] !== expected_results[0][11:0]
                        || m_tdata[29:12] !== expected_results[0][29:12]
                        || m_tdata[30] !== expected_results[0][30]
                        || m_tdata[31] !== 1'b0)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected temp %0d press %0d err %b, got temp %0d press %0d err %b",
                                $signed(expected_results[0][11:0]), expected_results[0][29:12],
                                expected_results[0][30], $signed(m_tdata[11:0]), m_tdata[29:12],
                                m_tdata[30]);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_results.pop_front());
                end
            end
        end
    end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import bptc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off = 1'b0;
    longint      cycle_count = 0;

    always #5 clk = ~clk;

    baro_pressure_temp_compensation_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    baro_comp_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("baro_pressure_temp_compensation_top regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= !hold_off && ($urandom_range(99, 0) >= recv_idle_pct);

    // The valid stays high after an item so that items can follow back to back;
    // drain() lowers it at the end of a run of items.
    task automatic send_item(logic [15:0] raw_t, logic [23:0] raw_p);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {raw_p, raw_t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (90) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_coefs(logic [31:0] a12, logic [31:0] a34, logic [31:0] a56,
                              logic [31:0] b12, logic [31:0] mcmd, logic [1:0] oss);
        write_reg(REG_AC1_AC2, a12);
        write_reg(REG_AC3_AC4, a34);
        write_reg(REG_AC5_AC6, a56);
        write_reg(REG_B1_B2, b12);
        write_reg(REG_MC_MD, mcmd);
        write_reg(REG_OSS, {30'd0, oss});
    endtask

    task automatic load_typical(logic [1:0] oss);
        load_coefs({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                   {16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, oss);
    endtask

    task automatic send_typical();
        send_item(16'd27898 + 16'($urandom_range(6000, 0)) - 16'd3000,
                  24'd23843 * 24'd256 + 24'($urandom_range(1 << 20, 0)));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Reset coefficients: the temperature divisor is zero.
        send_item(16'h0000, 24'h000000);
        send_item(16'hFFFF, 24'hFFFFFF);
        drain();
        load_typical(2'd0);
        send_item(16'd27898, 24'd23843 << 8);
        send_item(16'h0000, 24'h000000);
        send_item(16'hFFFF, 24'hFFFFFF);
        send_item(16'hFFFF, 24'h000000);
        drain();
        load_typical(2'd3);
        send_item(16'd27898, 24'd23843 << 8);
        send_item(16'hFFFF, 24'hFFFFFF);
        send_item(16'h0000, 24'hFFFFFF);
        drain();
        // ac4 zero makes b4 zero, then md zero with x1 at zero makes the temperature divisor zero.
        load_coefs({16'd408, -16'sd72}, {-16'sd14383, 16'd0}, 32'd0, 32'd0,
                   {16'd1, 16'd5}, 2'd1);
        send_item(16'd100, 24'd12345);
        drain();
        write_reg(REG_MC_MD, {16'd1, 16'd0});
        send_item(16'd100, 24'd12345);
        drain();
        load_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 2'd2);
        send_item(16'h0000, 24'h000000);
        send_item(16'hFFFF, 24'hFFFFFF);
        send_item(16'h8000, 24'h800000);
        drain();
        load_coefs(32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                   32'h8000_7FFF, 2'd3);
        send_item(16'h0000, 24'h000000);
        send_item(16'hFFFF, 24'hFFFFFF);
        send_item(16'h5555, 24'hAAAAAA);
        drain();
        write_reg(3'd7, 32'hDEAD_BEEF);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 21 : 0;
            for (int blk = 0; blk < 4; blk++)
            begin
                if (blk == 0)
                    load_typical(2'($urandom_range(3, 0)));
                else
                    load_coefs($urandom, $urandom, $urandom, $urandom,
                               $urandom, 2'($urandom_range(3, 0)));
                if (phase == 2 && blk == 1)
                begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (300) @(posedge clk);
                            hold_off = 1'b0;
                        end
                        for (int k = 0; k < 120; k++)
                            send_item(16'($urandom), 24'($urandom));
                    join
                end
                else
                begin
                    for (int k = 0; k < 48; k++)
                    begin
                        if (blk == 0 || $urandom_range(3, 0) == 0)
                            send_typical();
                        else
                            send_item(16'($urandom), 24'($urandom));
                    end
                end
                drain();
            end
        end

        drain();
        if (fail_count == 0)
            $display("baro_pressure_temp_compensation_top regression: pass");
        else
            $display("baro_pressure_temp_compensation_top regression: fail");
        $finish;
    end
endmodule

// File: sim.f
hdl/bptc_pkg.sv
hdl/bptc_div.sv
hdl/baro_pressure_temp_compensation_top.sv
tb/baro_comp_checker.sv
tb/tb.sv
